// File: src/lrub_pkg.sv
// ----------------------------------------------------------------------------
// lrub_pkg
// Shared types for the LRU slot replacement block: opcodes, controller states,
// and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package lrub_pkg;

  localparam int OpW   = 2;
  localparam int SlotW = 6;

  typedef enum logic [OpW-1:0] {
    OP_LINK_HEAD   = 2'd0,
    OP_INSERT_FREE = 2'd1,
    OP_SELECT      = 2'd2,
    OP_SET_PIN     = 2'd3
  } opcode_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_DETACH,
    ST_LINK,
    ST_LINK_HEAD,
    ST_FREE,
    ST_POP,
    ST_WALK_RD,
    ST_WALK_CK,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    RD_SLOT,
    RD_FREE,
    RD_CUR
  } rd_sel_e;

  typedef enum logic [1:0] {
    RES_ZERO,
    RES_POP,
    RES_EVICT,
    RES_NONE
  } res_kind_e;

  typedef struct packed {
    logic      clr_step;
    logic      load;
    logic      rd_en;
    rd_sel_e   rd_sel;
    logic      detach;
    logic      wr_link;
    logic      wr_head_prev;
    logic      wr_free;
    logic      wr_pin;
    logic      pop_free;
    logic      walk_init;
    logic      walk_step;
    logic      set_res;
    res_kind_e res_kind;
    logic      out_load;
  } cmd_t;

  typedef struct packed {
    logic    clr_done;
    opcode_e op;
    logic    slot_ok;
    logic    free_valid;
    logic    cur_valid;
    logic    steps_done;
    logic    cur_pinned;
    logic    out_free;
  } sts_t;

endpackage

// File: src/lrub_dp.sv
// ----------------------------------------------------------------------------
// lrub_dp
// Link memories, pin marks, list pointers, tail walk cursor and result register.
// ----------------------------------------------------------------------------
module lrub_dp import lrub_pkg::*; #(
  parameter int NUM_SLOTS = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cmd_t       cmd_i,
  output sts_t       sts_o,
  input  logic [7:0] in_tdata_i,   // slot_index[5:0], pin_value[6]
  input  logic [1:0] in_tuser_i,   // opcode[1:0]
  input  logic       out_tready_i,
  output logic       out_tvalid_o,
  output logic [7:0] out_tdata_o   // chosen_slot[5:0], status[6], evict[7]
);

  localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int LW = $clog2(NUM_SLOTS + 1);
  localparam logic [LW-1:0] Nil = LW'(NUM_SLOTS);

  logic [LW-1:0] next_mem [NUM_SLOTS];
  logic [LW-1:0] prev_mem [NUM_SLOTS];
  logic          pin_mem  [NUM_SLOTS];

  logic [LW-1:0] head_q, tail_q, free_q, cur_q, steps_q, clr_q;
  logic [SW-1:0] slot_q;
  logic          slot_ok_q, pin_q;
  opcode_e       op_q;
  logic [LW-1:0] nx_q, pv_q;
  logic          pin_rd_q;
  logic [SlotW-1:0] res_slot_q;
  logic          res_status_q, res_evict_q;
  logic          out_valid_q;
  logic [7:0]    out_data_q;

  logic [LW-1:0] slot_l;
  logic [SW-1:0] raddr;
  logic          nx_ok, pv_ok, head_ok;
  logic          nw_en, pw_en;
  logic [SW-1:0] nw_addr, pw_addr;
  logic [LW-1:0] nw_data, pw_data;

  assign slot_l  = LW'(slot_q);
  assign nx_ok   = nx_q < Nil;
  assign pv_ok   = pv_q < Nil;
  assign head_ok = head_q < Nil;

  always_comb begin
    unique case (cmd_i.rd_sel)
      RD_FREE: raddr = free_q[SW-1:0];
      RD_CUR:  raddr = cur_q[SW-1:0];
      default: raddr = slot_q;
    endcase
  end

  // next link write port
  always_comb begin
    nw_en   = 1'b0;
    nw_addr = slot_q;
    nw_data = Nil;
    if (cmd_i.clr_step) begin
      nw_en   = 1'b1;
      nw_addr = clr_q[SW-1:0];
      nw_data = clr_q + LW'(1);
    end else if (cmd_i.detach) begin
      nw_en   = pv_ok;
      nw_addr = pv_q[SW-1:0];
      nw_data = nx_q;
    end else if (cmd_i.wr_link) begin
      nw_en   = 1'b1;
      nw_data = head_q;
    end else if (cmd_i.wr_free) begin
      nw_en   = 1'b1;
      nw_data = free_q;
    end
  end

  // prev link write port
  always_comb begin
    pw_en   = 1'b0;
    pw_addr = slot_q;
    pw_data = Nil;
    if (cmd_i.clr_step) begin
      pw_en   = 1'b1;
      pw_addr = clr_q[SW-1:0];
    end else if (cmd_i.detach) begin
      pw_en   = nx_ok;
      pw_addr = nx_q[SW-1:0];
      pw_data = pv_q;
    end else if (cmd_i.wr_link || cmd_i.wr_free) begin
      pw_en   = 1'b1;
    end else if (cmd_i.wr_head_prev) begin
      pw_en   = head_ok;
      pw_addr = head_q[SW-1:0];
      pw_data = slot_l;
    end
  end

  always_ff @(posedge clk_i) begin
    if (nw_en) next_mem[nw_addr] <= nw_data;
    if (pw_en) prev_mem[pw_addr] <= pw_data;
    if (cmd_i.clr_step) pin_mem[clr_q[SW-1:0]] <= 1'b0;
    else if (cmd_i.wr_pin) pin_mem[slot_q] <= pin_q;
    if (cmd_i.rd_en) begin
      nx_q     <= next_mem[raddr];
      pv_q     <= prev_mem[raddr];
      pin_rd_q <= pin_mem[raddr];
    end
  end

  // item fields, result payload and tail walk cursor
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      slot_q    <= SW'(in_tdata_i[SlotW-1:0]);
      slot_ok_q <= 32'(in_tdata_i[SlotW-1:0]) < NUM_SLOTS;
      pin_q     <= in_tdata_i[SlotW];
      op_q      <= opcode_e'(in_tuser_i);
    end
    if (cmd_i.set_res) begin
      res_slot_q   <= '0;
      res_status_q <= 1'b0;
      res_evict_q  <= 1'b0;
      case (cmd_i.res_kind)
        RES_POP:   res_slot_q <= SlotW'(free_q);
        RES_EVICT: begin
          res_slot_q  <= SlotW'(cur_q);
          res_evict_q <= 1'b1;
        end
        RES_NONE:  res_status_q <= 1'b1;
        default:   ;
      endcase
    end
    if (cmd_i.out_load) out_data_q <= {res_evict_q, res_status_q, res_slot_q};
    if (cmd_i.walk_init) cur_q <= tail_q;
    else if (cmd_i.walk_step) cur_q <= pv_q;
    if (cmd_i.walk_init) steps_q <= '0;
    else if (cmd_i.walk_step) steps_q <= steps_q + LW'(1);
  end

  // list pointers, clear counter, output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= Nil;
      tail_q      <= Nil;
      free_q      <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clr_step) clr_q <= clr_q + LW'(1);
      if (cmd_i.detach) begin
        if (head_q == slot_l) head_q <= nx_q;
        if (tail_q == slot_l) tail_q <= pv_q;
      end
      if (cmd_i.wr_head_prev) begin
        head_q <= slot_l;
        if (!(tail_q < Nil)) tail_q <= slot_l;
      end
      if (cmd_i.wr_free) free_q <= slot_l;
      else if (cmd_i.pop_free) free_q <= nx_q;
      if (cmd_i.out_load) out_valid_q <= 1'b1;
      else if (out_tready_i) out_valid_q <= 1'b0;
    end
  end

  assign sts_o.clr_done   = clr_q == Nil;
  assign sts_o.op         = op_q;
  assign sts_o.slot_ok    = slot_ok_q;
  assign sts_o.free_valid = free_q < Nil;
  assign sts_o.cur_valid  = cur_q < Nil;
  assign sts_o.steps_done = steps_q == Nil;
  assign sts_o.cur_pinned = pin_rd_q;
  assign sts_o.out_free   = !out_valid_q || out_tready_i;

  assign out_tvalid_o = out_valid_q;
  assign out_tdata_o  = out_data_q;

endmodule

// File: src/lrub_ctrl.sv
// ----------------------------------------------------------------------------
// lrub_ctrl
// Sequencer: clear pass, per-opcode pointer update steps and the tail walk.
// ----------------------------------------------------------------------------
module lrub_ctrl import lrub_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_tvalid_i,
  output logic in_tready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_CLEAR;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    cmd_o.rd_sel   = RD_SLOT;
    cmd_o.res_kind = RES_ZERO;
    in_tready_o = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        if (sts_i.clr_done) state_d = ST_IDLE;
        else cmd_o.clr_step = 1'b1;
      end
      ST_IDLE: begin
        in_tready_o = 1'b1;
        if (in_tvalid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DECODE;
        end
      end
      ST_DECODE: begin
        cmd_o.set_res = 1'b1;
        if (sts_i.op == OP_SELECT) begin
          if (sts_i.free_valid) begin
            cmd_o.rd_en  = 1'b1;
            cmd_o.rd_sel = RD_FREE;
            state_d      = ST_POP;
          end else begin
            cmd_o.walk_init = 1'b1;
            state_d         = ST_WALK_RD;
          end
        end else if (!sts_i.slot_ok) begin
          state_d = ST_DONE;
        end else if (sts_i.op == OP_SET_PIN) begin
          cmd_o.wr_pin = 1'b1;
          state_d      = ST_DONE;
        end else begin
          cmd_o.rd_en = 1'b1;
          state_d     = ST_DETACH;
        end
      end
      ST_DETACH: begin
        cmd_o.detach = 1'b1;
        state_d = (sts_i.op == OP_LINK_HEAD) ? ST_LINK : ST_FREE;
      end
      ST_LINK: begin
        cmd_o.wr_link = 1'b1;
        state_d       = ST_LINK_HEAD;
      end
      ST_LINK_HEAD: begin
        cmd_o.wr_head_prev = 1'b1;
        state_d            = ST_DONE;
      end
      ST_FREE: begin
        cmd_o.wr_free = 1'b1;
        state_d       = ST_DONE;
      end
      ST_POP: begin
        cmd_o.set_res  = 1'b1;
        cmd_o.res_kind = RES_POP;
        cmd_o.pop_free = 1'b1;
        state_d        = ST_DONE;
      end
      ST_WALK_RD: begin
        if (!sts_i.cur_valid || sts_i.steps_done) begin
          cmd_o.set_res  = 1'b1;
          cmd_o.res_kind = RES_NONE;
          state_d        = ST_DONE;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_CUR;
          state_d      = ST_WALK_CK;
        end
      end
      ST_WALK_CK: begin
        if (!sts_i.cur_pinned) begin
          cmd_o.set_res  = 1'b1;
          cmd_o.res_kind = RES_EVICT;
          state_d        = ST_DONE;
        end else begin
          cmd_o.walk_step = 1'b1;
          state_d         = ST_WALK_RD;
        end
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// File: src/lru_buffer_replacement.sv
// ----------------------------------------------------------------------------
// lru_buffer_replacement
// Buffer slot manager: free list plus doubly linked LRU list, victim select.
// ----------------------------------------------------------------------------
// Usage:
//   Input items arrive on s_axis: tuser carries the opcode (link_head,
//   insert_free, select, set_pin), tdata the slot index and pin value.
//   Every item yields exactly one result item on m_axis: chosen slot,
//   status (1 = no unpinned buffer) and evict flag.
//   One item is in work at a time; s_axis_tready is high only when idle.
//   Processing time depends on the opcode and, for a tail walk, on the
//   number of visited slots: each pointer hop through the single read
//   port of the link memories is one read then use.
//   After reset a clearing pass chains all slots on the free list;
//   s_axis_tready stays low during it.
//   A finished result waits in the output register while m_axis_tready is
//   low; the next item is already accepted and worked on meanwhile.
// ----------------------------------------------------------------------------
module lru_buffer_replacement import lrub_pkg::*; #(
  parameter int NUM_SLOTS = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // slot_index[5:0], pin_value[6], zero[7]
  input  logic [1:0] s_axis_tuser,   // opcode[1:0]
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata    // chosen_slot[5:0], status[6], evict[7]
);

  cmd_t cmd;
  sts_t sts;

  lrub_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_tvalid_i (s_axis_tvalid),
    .in_tready_o (s_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  lrub_dp #(.NUM_SLOTS(NUM_SLOTS)) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .in_tdata_i   (s_axis_tdata),
    .in_tuser_i   (s_axis_tuser),
    .out_tready_i (m_axis_tready),
    .out_tvalid_o (m_axis_tvalid),
    .out_tdata_o  (m_axis_tdata)
  );

`ifndef SYNTHESIS
  // one item at a time: no accept right after an accept
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("accepted two items back to back");

  // no-buffer result carries no slot and no evict
  a_none_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[6]) |-> (m_axis_tdata[5:0] == 6'd0 && !m_axis_tdata[7]))
    else $error("no-buffer result with slot or evict set");

  // a result is loaded only from the done step, which follows an accept
  a_load_after_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> !s_axis_tready)
    else $error("result loaded while idle");
`endif

endmodule

// File: tb/sv/lru_buffer_replacement_tb.sv
// ----------------------------------------------------------------------------
// lru_buffer_replacement_tb
// Self-checking bench: directed table then random op mix, each result checked
// against an in-bench model of the free list and recency list.
// ----------------------------------------------------------------------------
module lru_buffer_replacement_tb;
  import lrub_pkg::*;

  localparam int NSLOT = 64;
  localparam int NIL   = NSLOT;

  typedef struct packed {
    logic [5:0] slot;
    logic       status;
    logic       evict;
  } res_t;

  typedef struct {
    opcode_e    op;
    logic [5:0] slot;
    logic       pin;
    logic       known;  // expected result typed in
    res_t       res;
  } row_t;

  logic       clk_i = 0;
  logic       rst_ni = 0;
  logic       s_axis_tvalid = 0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = '0;
  logic [1:0] s_axis_tuser = '0;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 0;
  logic [7:0] m_axis_tdata;

  lru_buffer_replacement #(.NUM_SLOTS(NSLOT)) dut (.*);

  always #5 clk_i = ~clk_i;

  // model state
  int   nxt [NSLOT];
  int   prv [NSLOT];
  bit   pinned [NSLOT];
  int   head_r, tail_r, free_h;
  res_t pending_q [$];
  res_t last_res;      // model result of the most recent item sent
  int   errors = 0;
  bit   hold_rx = 0;   // long receiver hold-off
  bit   stim_done = 0;

  function automatic void model_reset();
    for (int i = 0; i < NSLOT; i++) begin
      nxt[i] = i + 1;
      prv[i] = NIL;
      pinned[i] = 0;
    end
    head_r = NIL;
    tail_r = NIL;
    free_h = 0;
  endfunction

  function automatic void unlink_slot(int s);
    int nx, pv;
    nx = nxt[s];
    pv = prv[s];
    if (head_r == s) head_r = nx;
    if (tail_r == s) tail_r = pv;
    if (nx < NSLOT) prv[nx] = pv;
    if (pv < NSLOT) nxt[pv] = nx;
    nxt[s] = NIL;
    prv[s] = NIL;
  endfunction

  function automatic res_t apply_op(opcode_e op, int s, bit pin);
    res_t r;
    int cur, steps;
    r = '0;
    if (op == OP_SELECT) begin
      if (free_h < NSLOT) begin
        r.slot = free_h[5:0];
        free_h = nxt[free_h];
      end else begin
        cur = tail_r;
        steps = 0;
        while (cur < NSLOT && steps < NSLOT && pinned[cur]) begin
          cur = prv[cur];
          steps++;
        end
        if (cur < NSLOT && steps < NSLOT) begin
          r.slot = cur[5:0];
          r.evict = 1;
        end else begin
          r.status = 1;
        end
      end
    end else if (op == OP_LINK_HEAD) begin
      unlink_slot(s);
      nxt[s] = head_r;
      prv[s] = NIL;
      if (head_r < NSLOT) prv[head_r] = s;
      head_r = s;
      if (tail_r >= NSLOT) tail_r = s;
    end else if (op == OP_INSERT_FREE) begin
      unlink_slot(s);
      nxt[s] = free_h;
      free_h = s;
    end else begin
      pinned[s] = pin;
    end
    return r;
  endfunction

  task automatic send_item(opcode_e op, logic [5:0] s, logic pin, bit known, res_t exp_r);
    res_t r;
    int   gap;
    r = apply_op(op, s, pin);
    if (known && r != exp_r) begin
      $display("%0t table/model mismatch: exp %h model %h", $time, exp_r, r);
      errors++;
    end
    last_res = r;
    pending_q.push_back(r);
    s_axis_tuser  <= op;
    s_axis_tdata  <= {1'b0, pin, s};
    s_axis_tvalid <= 1;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    // mostly back-to-back, sometimes short gap, rarely long
    gap = 0;
    if ($urandom_range(0, 2) == 0) gap = $urandom_range(1, 3);
    else if ($urandom_range(0, 40) == 0) gap = $urandom_range(10, 60);
    if (gap != 0) begin
      s_axis_tvalid <= 0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  task automatic wait_drain();
    s_axis_tvalid <= 0;
    while (pending_q.size() != 0) @(negedge clk_i);
  endtask

  function automatic res_t mk(logic [5:0] s, logic st, logic ev);
    res_t r;
    r.slot = s; r.status = st; r.evict = ev;
    return r;
  endfunction

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_rx) m_axis_tready <= 0;
      else if ($urandom_range(0, 30) == 0) m_axis_tready <= 0;
      else if (!m_axis_tready) m_axis_tready <= ($urandom_range(0, 3) == 0) ||
                                                ($urandom_range(0, 1) == 0);
      else m_axis_tready <= ($urandom_range(0, 4) != 0);
    end
  end

  // checker
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_q.size() == 0) begin
        $display("%0t unexpected item: actual %h", $time, m_axis_tdata);
        errors++;
      end else begin
        res_t e;
        e = pending_q.pop_front();
        if (m_axis_tdata[5:0] != e.slot) begin
          $display("%0t chosen_slot: expected %0d actual %0d", $time, e.slot,
                   m_axis_tdata[5:0]);
          errors++;
        end
        if (m_axis_tdata[6] != e.status) begin
          $display("%0t status: expected %0d actual %0d", $time, e.status,
                   m_axis_tdata[6]);
          errors++;
        end
        if (m_axis_tdata[7] != e.evict) begin
          $display("%0t evict: expected %0d actual %0d", $time, e.evict,
                   m_axis_tdata[7]);
          errors++;
        end
      end
    end
  end

  row_t tbl [$];

  task automatic add_row(opcode_e op, logic [5:0] s, logic p, bit k, res_t r);
    row_t w;
    w.op = op; w.slot = s; w.pin = p; w.known = k; w.res = r;
    tbl.push_back(w);
  endtask

  // random phase: build recency list, pin some, drain free list, evict
  task automatic random_item(int mode);
    int u;
    opcode_e op;
    logic [5:0] s;
    u = $urandom_range(0, 99);
    s = $urandom_range(0, NSLOT - 1);
    if (mode == 0) begin
      // well-formed: select then link the chosen slot
      if (u < 45) op = OP_SELECT;
      else if (u < 65) op = OP_SET_PIN;
      else if (u < 80) op = OP_INSERT_FREE;
      else op = OP_LINK_HEAD;
    end else begin
      op = opcode_e'($urandom_range(0, 3));
    end
    if (op == OP_SELECT) begin
      res_t r;
      send_item(OP_SELECT, s, $urandom_range(0, 1), 0, '0);
      r = last_res;
      if (mode == 0 && !r.status && $urandom_range(0, 4) != 0)
        send_item(OP_LINK_HEAD, r.slot, $urandom_range(0, 1), 0, '0);
    end else begin
      // pinning kept sparse so evictions happen
      send_item(op, s, (op == OP_SET_PIN) ? ($urandom_range(0, 2) == 0) :
                $urandom_range(0, 1), 0, '0);
    end
  endtask

  initial begin
    model_reset();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1;

    // directed table
    add_row(OP_SELECT,      6'd33, 1, 1, mk(6'd0, 0, 0));   // free pop ignores fields
    add_row(OP_SELECT,      6'd0,  0, 1, mk(6'd1, 0, 0));
    add_row(OP_LINK_HEAD,   6'd0,  0, 1, mk(0, 0, 0));
    add_row(OP_LINK_HEAD,   6'd1,  1, 1, mk(0, 0, 0));
    add_row(OP_SET_PIN,     6'd63, 1, 1, mk(0, 0, 0));
    add_row(OP_INSERT_FREE, 6'd1,  0, 1, mk(0, 0, 0));
    for (int i = 0; i < 63; i++) add_row(OP_SELECT, 0, 0, 0, '0);  // drain free list
    add_row(OP_SELECT,      6'd0,  0, 0, '0);               // evict from tail
    add_row(OP_SET_PIN,     6'd0,  1, 1, mk(0, 0, 0));
    add_row(OP_SET_PIN,     6'd1,  1, 1, mk(0, 0, 0));
    add_row(OP_SELECT,      6'd0,  0, 1, mk(0, 1, 0));      // all pinned
    add_row(OP_SET_PIN,     6'd0,  0, 1, mk(0, 0, 0));
    add_row(OP_SELECT,      6'd0,  0, 1, mk(6'd0, 0, 1));
    add_row(OP_LINK_HEAD,   6'd62, 0, 0, '0);               // broken chain case
    add_row(OP_SELECT,      6'd5,  1, 0, '0);
    add_row(OP_INSERT_FREE, 6'd0,  1, 0, '0);
    add_row(OP_SELECT,      6'd0,  0, 0, '0);
    foreach (tbl[i]) send_item(tbl[i].op, tbl[i].slot, tbl[i].pin, tbl[i].known,
                               tbl[i].res);

    // sender pause until drained
    wait_drain();

    // long receiver hold-off while sender keeps offering
    hold_rx = 1;
    fork
      begin repeat (300) @(negedge clk_i); hold_rx = 0; end
      repeat (20) random_item(1);
    join

    for (int n = 0; n < 400; n++) begin
      random_item(($urandom_range(0, 9) < 8) ? 0 : 1);
      if (n == 200) wait_drain();
    end

    wait_drain();
    repeat (2 * NSLOT + 20) @(negedge clk_i);
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  // timeout watchdog: counts as failure if the queue never empties
  initial begin
    #20000000;
    $display("RESULT: ERROR");
    $finish;
  end
endmodule
